FILE: rtl/core/cpc_pkg.sv
// Shared types, widths and codes of the cascade PID controller.
package cpc_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned ERR_W     = SAMPLE_W + 1;
  localparam int unsigned DERIV_W   = SAMPLE_W + 2;
  localparam int unsigned OPND_W    = SUM_W;
  localparam int unsigned PROD_W    = OPND_W + GAIN_W;
  localparam int unsigned TERM_W    = PROD_W - FRAC_W;
  localparam int unsigned TOTAL_W   = TERM_W + 2;
  localparam int unsigned BITCNT_W  = $clog2(GAIN_W);
  localparam int unsigned NUM_GAINS = 6;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY_BASE = 3'd3;

  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic signed [TOTAL_W-1:0] TOTAL_SMAX =
    {{(TOTAL_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_SMIN =
    {{(TOTAL_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] primary_target;
    logic signed [SAMPLE_W-1:0] secondary_target;
    logic signed [SAMPLE_W-1:0] measurement;
  } cpc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive;
    logic signed [SAMPLE_W-1:0] inner_result;
  } cpc_out_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ERR   = 6'b000010,
    S_START = 6'b000100,
    S_MUL   = 6'b001000,
    S_SAT   = 6'b010000,
    S_OUT   = 6'b100000
  } cpc_state_e;

endpackage

FILE: rtl/core/cpc_serial_mul.sv
// Bit-serial signed multiplier: one gain bit per cycle, shift-add into a split accumulator.
module cpc_serial_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [cpc_pkg::GAIN_W-1:0]    gain_i,
  input  logic signed [cpc_pkg::OPND_W-1:0]    opnd_i,
  output logic                                 done_o,
  output logic signed [cpc_pkg::PROD_W-1:0]    prod_o
);
  import cpc_pkg::*;

  localparam int unsigned HI_W = OPND_W + 2;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [BITCNT_W-1:0]   cnt_q, cnt_d;
  logic [GAIN_W-1:0]     gain_q, gain_d;
  logic [OPND_W-1:0]     opnd_q, opnd_d;
  logic [HI_W-1:0]       hi_q, hi_d;
  logic [GAIN_W-1:0]     lo_q, lo_d;
  logic [HI_W-1:0]       opnd_ext;
  logic [HI_W-1:0]       sum;
  logic                  last_bit;

  assign opnd_ext = {{(HI_W-OPND_W){opnd_q[OPND_W-1]}}, opnd_q};
  assign last_bit = (cnt_q == BITCNT_W'(GAIN_W - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    gain_d = gain_q;
    opnd_d = opnd_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    sum    = hi_q;
    if (gain_q[0]) begin
      sum = last_bit ? (hi_q - opnd_ext) : (hi_q + opnd_ext);
    end
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      gain_d = gain_i;
      opnd_d = opnd_i;
      hi_d   = '0;
      lo_d   = '0;
    end else if (busy_q) begin
      hi_d   = {sum[HI_W-1], sum[HI_W-1:1]};
      lo_d   = {sum[0], lo_q[GAIN_W-1:1]};
      gain_d = {1'b0, gain_q[GAIN_W-1:1]};
      cnt_d  = cnt_q + BITCNT_W'(1);
      if (last_bit) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gain_q <= gain_d;
    opnd_q <= opnd_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = $signed({hi_q[OPND_W-1:0], lo_q});

endmodule

FILE: rtl/core/cpc_stage.sv
// PID stage state: error, saturating error sum, last error and derivative.
module cpc_stage (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic signed [cpc_pkg::SAMPLE_W-1:0]  target_i,
  input  logic signed [cpc_pkg::SAMPLE_W-1:0]  actual_i,
  output logic signed [cpc_pkg::ERR_W-1:0]     err_o,
  output logic signed [cpc_pkg::SUM_W-1:0]     sum_o,
  output logic signed [cpc_pkg::DERIV_W-1:0]   deriv_o
);
  import cpc_pkg::*;

  logic [ERR_W-1:0]   err;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [ERR_W-1:0]   last_q;
  logic [DERIV_W-1:0] deriv_q, deriv_d;

  assign err = {target_i[SAMPLE_W-1], target_i} - {actual_i[SAMPLE_W-1], actual_i};
  assign sum_wide = {sum_q[SUM_W-1], sum_q} + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
  assign deriv_d  = {err[ERR_W-1], err} - {last_q[ERR_W-1], last_q};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_d = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_d = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      last_q  <= '0;
      deriv_q <= '0;
    end else if (load_i) begin
      sum_q   <= sum_d;
      last_q  <= err;
      deriv_q <= deriv_d;
    end
  end

  assign err_o   = $signed(last_q);
  assign sum_o   = $signed(sum_q);
  assign deriv_o = $signed(deriv_q);

endmodule

FILE: rtl/core/cascade_pid_controller.sv
// Top level of the cascade PID controller: gains, sequencer, accumulation and output register.
// Requests are taken only in S_IDLE; in_stall_o holds new requests off until the result is issued.
// Each stage runs three bit-serial multiplies (P, I and D terms: start, one shift per gain bit,
// done) in turn on the shared multiplier.
// A finished result waits in the output register while the next request runs.
// Reset clears gains, error sums and last errors to zero.
module cascade_pid_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cpc_pkg::cpc_in_t                  in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cpc_pkg::cpc_out_t                 out_req_o,
  input  logic                              cfg_we_i,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cpc_pkg::GAIN_W-1:0]        cfg_wdata_i
);
  import cpc_pkg::*;

  cpc_state_e           state_q, state_d;
  logic                 stage_q, stage_d;
  logic [1:0]           term_q, term_d;
  logic [GAIN_W-1:0]    gain_q [NUM_GAINS];
  cpc_in_t              req_q;
  logic [SAMPLE_W-1:0]  inner_q;
  logic [SAMPLE_W-1:0]  drive_q;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic                 out_valid_q, out_valid_d;
  cpc_out_t             out_q;
  logic                 in_acc;
  logic                 load1, load2;
  logic                 mul_start, mul_done;
  logic [CFG_IDX_W-1:0] gain_idx;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ERR_W-1:0]   err1, err2, err_sel;
  logic signed [SUM_W-1:0]   sum1, sum2, sum_sel;
  logic signed [DERIV_W-1:0] deriv1, deriv2, deriv_sel;
  logic [SAMPLE_W-1:0]  sat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load1      = (state_q == S_ERR) && !stage_q;
  assign load2      = (state_q == S_ERR) && stage_q;
  assign mul_start  = (state_q == S_START);

  cpc_stage u_stage1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load1),
    .target_i (req_q.primary_target),
    .actual_i (req_q.measurement),
    .err_o    (err1),
    .sum_o    (sum1),
    .deriv_o  (deriv1)
  );

  cpc_stage u_stage2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load2),
    .target_i (req_q.secondary_target),
    .actual_i ($signed(inner_q)),
    .err_o    (err2),
    .sum_o    (sum2),
    .deriv_o  (deriv2)
  );

  assign err_sel   = stage_q ? err2 : err1;
  assign sum_sel   = stage_q ? sum2 : sum1;
  assign deriv_sel = stage_q ? deriv2 : deriv1;
  assign gain_idx  = (stage_q ? CFG_SECONDARY_BASE : CFG_PRIMARY_BASE)
                     + {{(CFG_IDX_W-2){1'b0}}, term_q};

  always_comb begin
    case (term_q)
      TERM_P:  opnd = {{(OPND_W-ERR_W){err_sel[ERR_W-1]}}, err_sel};
      TERM_I:  opnd = sum_sel;
      default: opnd = {{(OPND_W-DERIV_W){deriv_sel[DERIV_W-1]}}, deriv_sel};
    endcase
  end

  cpc_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .gain_i  ($signed(gain_q[gain_idx])),
    .opnd_i  (opnd),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  always_comb begin
    if ($signed(total_q) > TOTAL_SMAX) begin
      sat = TOTAL_SMAX[SAMPLE_W-1:0];
    end else if ($signed(total_q) < TOTAL_SMIN) begin
      sat = TOTAL_SMIN[SAMPLE_W-1:0];
    end else begin
      sat = total_q[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    term_d      = term_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          stage_d = 1'b0;
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        term_d  = TERM_P;
        total_d = '0;
        state_d = S_START;
      end
      S_START: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          total_d = total_q + {{(TOTAL_W-TERM_W){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC_W]};
          term_d  = term_q + 2'd1;
          state_d = (term_q == TERM_D) ? S_SAT : S_START;
        end
      end
      S_SAT: begin
        if (!stage_q) begin
          stage_d = 1'b1;
          state_d = S_ERR;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stage_q     <= 1'b0;
      term_q      <= TERM_P;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_GAINS; i++) begin
        gain_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_GAINS))) begin
        gain_q[cfg_idx_i] <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    if (in_acc) begin
      req_q <= in_req_i;
    end
    if (state_q == S_SAT) begin
      if (!stage_q) begin
        inner_q <= sat;
      end else begin
        drive_q <= sat;
      end
    end
    if ((state_q == S_OUT) && (!out_valid_q || !out_stall_i)) begin
      out_q.drive        <= $signed(drive_q);
      out_q.inner_result <= $signed(inner_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request accepted but block not busy");

  a_done_in_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MUL))
    else $error("multiplier finished outside its wait state");

  a_result_from_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output state");

  a_second_stage_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> stage_q)
    else $error("output reached before second stage");

endmodule
